/* rtl/core/hpf4_pkg.sv */
// Shared types and constants for the multichannel fourth-order highpass IIR filter.
package hpf4_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int FRAC_BITS   = COEF_BITS - 4;
    localparam int CHAN_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int NSTAGE      = 4;

    // The numerator sum of five taps fits in four extra bits.
    localparam int NUM_W = SAMPLE_BITS + 4;
    localparam int PG_W  = COEF_BITS + NUM_W;
    localparam int PB_W  = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W = PG_W + 3;
    localparam int Y_W   = ACC_W - FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic [CHAN_W-1:0]             chan_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 3'd0,
        REG_FB_1 = 3'd1,
        REG_FB_2 = 3'd2,
        REG_FB_3 = 3'd3,
        REG_FB_4 = 3'd4
    } reg_idx_t;

    typedef enum logic {
        ACT_FILTER = 1'b0,
        ACT_CLEAR  = 1'b1
    } action_t;

    typedef struct packed {
        action_t action;
        chan_t   channel_index;
        sample_t sample_in;
    } in_item_t;

    typedef struct packed {
        sample_t sample_out;
        chan_t   channel_out;
        logic    saturated;
    } out_item_t;

    typedef struct packed {
        coef_t gain;
        coef_t fb_1;
        coef_t fb_2;
        coef_t fb_3;
        coef_t fb_4;
    } coef_set_t;

    // Four-deep history, h1 is the newest entry.
    typedef struct packed {
        sample_t h1;
        sample_t h2;
        sample_t h3;
        sample_t h4;
    } hist_t;

    typedef struct packed {
        logic  busy;
        logic  clr;
        chan_t ch;
    } stage_tag_t;

    typedef struct packed {
        stage_tag_t [NSTAGE-1:0] tag;
        logic                    retire;
    } pipe_status_t;

    typedef struct packed {
        logic  wr;
        logic  clr;
        chan_t ch;
        hist_t xh;
        hist_t yh;
    } wb_t;

endpackage

/* rtl/core/hpf4_hist_mem.sv */
// Per-channel input and output history memories with valid bits and write bypass.
module hpf4_hist_mem #(
    parameter int CHANNELS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  hpf4_pkg::chan_t  rd_ch,
    input  hpf4_pkg::wb_t    wb,
    output hpf4_pkg::hist_t  rd_xh,
    output hpf4_pkg::hist_t  rd_yh
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    hpf4_pkg::hist_t x_mem [CHANNELS];
    hpf4_pkg::hist_t y_mem [CHANNELS];
    hpf4_pkg::hist_t x_rd_reg;
    hpf4_pkg::hist_t y_rd_reg;
    logic            rd_vld_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic [CHANNELS-1:0] vld_next;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            bypass;

    assign rd_addr = AW'(rd_ch);
    assign wr_addr = AW'(wb.ch);
    assign bypass  = wb.wr && (wb.ch == rd_ch);

    always_ff @(posedge clk)
    begin
        if (wb.wr)
        begin
            x_mem[wr_addr] <= wb.xh;
            y_mem[wr_addr] <= wb.yh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (bypass)
            begin
                x_rd_reg <= wb.xh;
                y_rd_reg <= wb.yh;
            end
            else
            begin
                x_rd_reg <= x_mem[rd_addr];
                y_rd_reg <= y_mem[rd_addr];
            end
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (wb.clr)
        begin
            vld_next = '0;
        end
        else if (wb.wr)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                rd_vld_reg <= vld_next[rd_addr];
            end
        end
    end

    // An entry never written since reset or the last clear reads as zero.
    assign rd_xh = rd_vld_reg ? x_rd_reg : '0;
    assign rd_yh = rd_vld_reg ? y_rd_reg : '0;

endmodule

/* rtl/core/hpf4_pipe.sv */
// Four-stage filter datapath with output register and history write-back.
module hpf4_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  hpf4_pkg::in_item_t     item,
    input  hpf4_pkg::coef_set_t    coef,
    input  hpf4_pkg::hist_t        rd_xh,
    input  hpf4_pkg::hist_t        rd_yh,
    output logic                   ready,
    output hpf4_pkg::pipe_status_t status,
    output hpf4_pkg::wb_t          wb,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hpf4_pkg::out_item_t    out_data
);

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic s1_clr_reg, s2_clr_reg, s3_clr_reg, s4_clr_reg;
    hpf4_pkg::chan_t   s1_ch_reg, s2_ch_reg, s3_ch_reg, s4_ch_reg;
    hpf4_pkg::sample_t s1_x_reg, s2_x_reg, s3_x_reg, s4_x_reg;
    hpf4_pkg::hist_t   s2_xh_reg, s3_xh_reg, s4_xh_reg;
    hpf4_pkg::hist_t   s2_yh_reg, s3_yh_reg, s4_yh_reg;
    logic signed [hpf4_pkg::NUM_W-1:0] s2_num_reg;
    logic signed [hpf4_pkg::PG_W-1:0]  s3_pg_reg;
    logic signed [hpf4_pkg::PB_W-1:0]  s3_pb1_reg, s3_pb2_reg, s3_pb3_reg, s3_pb4_reg;
    logic signed [hpf4_pkg::ACC_W-1:0] s4_sa_reg, s4_sb_reg;
    hpf4_pkg::out_item_t out_data_reg;

    logic ld1, ld2, ld3, ld4, en_out, retire;

    logic signed [hpf4_pkg::NUM_W-1:0] nx, n1, n2, n3, n4, num;
    logic signed [hpf4_pkg::PG_W-1:0]  pg;
    logic signed [hpf4_pkg::PB_W-1:0]  pb1, pb2, pb3, pb4;
    logic signed [hpf4_pkg::ACC_W-1:0] sum_a, sum_b, acc;
    logic signed [hpf4_pkg::Y_W-1:0]   yw;
    logic                              hi, lo;
    hpf4_pkg::sample_t                 y;

    assign en_out = !out_v_reg || !out_stall;
    assign ld4    = !s4_v_reg || en_out;
    assign ld3    = !s3_v_reg || ld4;
    assign ld2    = !s2_v_reg || ld3;
    assign ld1    = !s1_v_reg || ld2;
    assign ready  = ld1;
    assign retire = s4_v_reg && en_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_v_reg <= load;
            end
            if (ld2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (ld3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (ld4)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s4_v_reg;
            end
        end
    end

    // Numerator taps 1, -4, 6, -4, 1 built from shifts.
    assign nx  = hpf4_pkg::NUM_W'(s1_x_reg);
    assign n1  = hpf4_pkg::NUM_W'(rd_xh.h1);
    assign n2  = hpf4_pkg::NUM_W'(rd_xh.h2);
    assign n3  = hpf4_pkg::NUM_W'(rd_xh.h3);
    assign n4  = hpf4_pkg::NUM_W'(rd_xh.h4);
    assign num = nx - (n1 <<< 2) + (n2 <<< 2) + (n2 <<< 1) - (n3 <<< 2) + n4;

    assign pg  = hpf4_pkg::PG_W'(coef.gain) * hpf4_pkg::PG_W'(s2_num_reg);
    assign pb1 = hpf4_pkg::PB_W'(coef.fb_1) * hpf4_pkg::PB_W'(s2_yh_reg.h1);
    assign pb2 = hpf4_pkg::PB_W'(coef.fb_2) * hpf4_pkg::PB_W'(s2_yh_reg.h2);
    assign pb3 = hpf4_pkg::PB_W'(coef.fb_3) * hpf4_pkg::PB_W'(s2_yh_reg.h3);
    assign pb4 = hpf4_pkg::PB_W'(coef.fb_4) * hpf4_pkg::PB_W'(s2_yh_reg.h4);

    assign sum_a = hpf4_pkg::ACC_W'(s3_pg_reg) - hpf4_pkg::ACC_W'(s3_pb1_reg)
                 - hpf4_pkg::ACC_W'(s3_pb2_reg);
    assign sum_b = hpf4_pkg::ROUND_HALF - hpf4_pkg::ACC_W'(s3_pb3_reg)
                 - hpf4_pkg::ACC_W'(s3_pb4_reg);

    assign acc = s4_sa_reg + s4_sb_reg;
    assign yw  = signed'(acc[hpf4_pkg::ACC_W-1:hpf4_pkg::FRAC_BITS]);
    assign hi  = yw > hpf4_pkg::Y_W'(hpf4_pkg::SAMPLE_MAX);
    assign lo  = yw < hpf4_pkg::Y_W'(hpf4_pkg::SAMPLE_MIN);

    always_comb
    begin
        if (hi)
        begin
            y = hpf4_pkg::SAMPLE_MAX;
        end
        else if (lo)
        begin
            y = hpf4_pkg::SAMPLE_MIN;
        end
        else
        begin
            y = signed'(yw[hpf4_pkg::SAMPLE_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_clr_reg <= (item.action == hpf4_pkg::ACT_CLEAR);
            s1_ch_reg  <= item.channel_index;
            s1_x_reg   <= item.sample_in;
        end
        if (ld2)
        begin
            s2_clr_reg <= s1_clr_reg;
            s2_ch_reg  <= s1_ch_reg;
            s2_x_reg   <= s1_x_reg;
            s2_xh_reg  <= rd_xh;
            s2_yh_reg  <= rd_yh;
            s2_num_reg <= num;
        end
        if (ld3)
        begin
            s3_clr_reg <= s2_clr_reg;
            s3_ch_reg  <= s2_ch_reg;
            s3_x_reg   <= s2_x_reg;
            s3_xh_reg  <= s2_xh_reg;
            s3_yh_reg  <= s2_yh_reg;
            s3_pg_reg  <= pg;
            s3_pb1_reg <= pb1;
            s3_pb2_reg <= pb2;
            s3_pb3_reg <= pb3;
            s3_pb4_reg <= pb4;
        end
        if (ld4)
        begin
            s4_clr_reg <= s3_clr_reg;
            s4_ch_reg  <= s3_ch_reg;
            s4_x_reg   <= s3_x_reg;
            s4_xh_reg  <= s3_xh_reg;
            s4_yh_reg  <= s3_yh_reg;
            s4_sa_reg  <= sum_a;
            s4_sb_reg  <= sum_b;
        end
        if (en_out)
        begin
            out_data_reg.sample_out  <= s4_clr_reg ? '0 : y;
            out_data_reg.channel_out <= s4_clr_reg ? '0 : s4_ch_reg;
            out_data_reg.saturated   <= !s4_clr_reg && (hi || lo);
        end
    end

    always_comb
    begin
        wb.wr    = retire && !s4_clr_reg;
        wb.clr   = retire && s4_clr_reg;
        wb.ch    = s4_ch_reg;
        wb.xh.h1 = s4_x_reg;
        wb.xh.h2 = s4_xh_reg.h1;
        wb.xh.h3 = s4_xh_reg.h2;
        wb.xh.h4 = s4_xh_reg.h3;
        wb.yh.h1 = y;
        wb.yh.h2 = s4_yh_reg.h1;
        wb.yh.h3 = s4_yh_reg.h2;
        wb.yh.h4 = s4_yh_reg.h3;
    end

    always_comb
    begin
        status.tag[0] = '{busy: s1_v_reg, clr: s1_clr_reg, ch: s1_ch_reg};
        status.tag[1] = '{busy: s2_v_reg, clr: s2_clr_reg, ch: s2_ch_reg};
        status.tag[2] = '{busy: s3_v_reg, clr: s3_clr_reg, ch: s3_ch_reg};
        status.tag[3] = '{busy: s4_v_reg, clr: s4_clr_reg, ch: s4_ch_reg};
        status.retire = retire;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/highpass_iir_order4_multichannel_top.sv */
// Top level of the multichannel fourth-order highpass IIR filter.
//
//   Channel  Direction  Handshake          Payload
//   in       sink       in_valid/in_stall    in_data (in_item_t)
//   out      source     out_valid/out_stall  out_data (out_item_t)
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle is accepted while the output does not stall, no clear is in flight
// and no item in the pipeline uses the sample's channel. A sample on a channel still in
// the four-stage read-modify-write loop of the history memory, or any sample behind a
// clear, waits until that item writes back, which a stalled output delays.
// Reset clears the coefficients and the per-channel valid bits; no clearing pass runs.
// A stalled output fills the pipeline bubbles before the input stalls.
module highpass_iir_order4_multichannel_top #(
    parameter int CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  hpf4_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output hpf4_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpf4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpf4_pkg::COEF_BITS-1:0]  cfg_data
);

    localparam int CH_SPAN = 1 << hpf4_pkg::CHAN_W;
    localparam int CH_LIM  = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;

    hpf4_pkg::coef_set_t    coef_reg;
    hpf4_pkg::chan_t        ch_red;
    hpf4_pkg::in_item_t     item;
    hpf4_pkg::pipe_status_t status;
    hpf4_pkg::wb_t          wb;
    hpf4_pkg::hist_t        rd_xh;
    hpf4_pkg::hist_t        rd_yh;
    logic                   pipe_ready;
    logic                   hazard;
    logic                   accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hpf4_pkg::REG_GAIN: coef_reg.gain <= signed'(cfg_data);
                hpf4_pkg::REG_FB_1: coef_reg.fb_1 <= signed'(cfg_data);
                hpf4_pkg::REG_FB_2: coef_reg.fb_2 <= signed'(cfg_data);
                hpf4_pkg::REG_FB_3: coef_reg.fb_3 <= signed'(cfg_data);
                hpf4_pkg::REG_FB_4: coef_reg.fb_4 <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Channel numbers at or above the channel count wrap around.
    always_comb
    begin
        ch_red = in_data.channel_index;
        for (int i = 0; i < CH_SPAN - 1; i++)
        begin
            if ({1'b0, ch_red} >= (hpf4_pkg::CHAN_W + 1)'(CH_LIM))
            begin
                ch_red = ch_red - hpf4_pkg::CHAN_W'(CH_LIM);
            end
        end
    end

    // A sample waits while an older item on its channel, or a clear, has not
    // written back yet; the stage that writes back in this cycle is bypassed.
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < hpf4_pkg::NSTAGE; k++)
        begin
            if (status.tag[k].busy && (status.tag[k].clr || status.tag[k].ch == ch_red)
                && !(k == hpf4_pkg::NSTAGE - 1 && status.retire))
            begin
                hazard = 1'b1;
            end
        end
        if (in_data.action == hpf4_pkg::ACT_CLEAR)
        begin
            hazard = 1'b0;
        end
    end

    assign in_stall = !pipe_ready || hazard;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item               = in_data;
        item.channel_index = ch_red;
    end

    hpf4_hist_mem #(
        .CHANNELS (CHANNELS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .rd_ch (ch_red),
        .wb    (wb),
        .rd_xh (rd_xh),
        .rd_yh (rd_yh)
    );

    hpf4_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .item      (item),
        .coef      (coef_reg),
        .rd_xh     (rd_xh),
        .rd_yh     (rd_yh),
        .ready     (pipe_ready),
        .status    (status),
        .wb        (wb),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/hpf4_checker.sv */
// Port-level checker for the highpass IIR filter top level, with its bind.
module hpf4_checker #(
    parameter int CHANNELS = 8
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input hpf4_pkg::out_item_t             out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn before its transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_data.channel_out) < CHANNELS)
        else $error("result reports a channel outside the channel count");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.sample_out == hpf4_pkg::SAMPLE_MAX ||
            out_data.sample_out == hpf4_pkg::SAMPLE_MIN)
        else $error("saturated result is not at a range limit");

endmodule

bind highpass_iir_order4_multichannel_top hpf4_checker #(.CHANNELS(CHANNELS)) u_chk (.*);
